// File: rtl/zchar_text_decoder_macros.svh
// Assertion helpers for the text decoder checker.
`ifndef ZCHAR_TEXT_DECODER_MACROS_SVH
`define ZCHAR_TEXT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZCTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("zctd check failed");

// The consequent must hold in the cycle after the antecedent.
`define ZCTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("zctd check failed");

`endif

// File: rtl/zctd_pkg.sv
package zctd_pkg;

    // Token kinds.
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_ABBR = 2'd1;
    localparam logic [1:0] KIND_ESC  = 2'd2;

    // Tokens produced by one word at most.
    localparam int unsigned MAX_TOKENS = 3;

    // One input transaction.
    typedef struct packed {
        logic [15:0] text_word;
        logic        start_of_string;
    } t_in_item;

    // One output transaction.
    typedef struct packed {
        logic [1:0] token_kind;
        logic [9:0] token_value;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] value;
    } t_token;

    // All tokens of one word, packed from slot 0; count is 1 to 3.
    typedef struct packed {
        logic [1:0]                 count;
        t_token [MAX_TOKENS-1:0]    tok;
    } t_group;

endpackage

// File: rtl/zctd_front.sv
module zctd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  zctd_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  logic              i_full,
    output logic              o_push,
    output zctd_pkg::t_group  o_group
);
    import zctd_pkg::*;

    typedef enum logic [1:0] {
        ALPHA_LOWER = 2'd0,
        ALPHA_UPPER = 2'd1,
        ALPHA_PUNCT = 2'd2
    } t_alpha;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_ABBR    = 2'd1,
        PEND_ESC_TOP = 2'd2,
        PEND_ESC_BOT = 2'd3
    } t_pend;

    localparam logic [4:0] CODE_SPACE    = 5'd0;
    localparam logic [4:0] CODE_ABBR_LO  = 5'd1;
    localparam logic [4:0] CODE_ABBR_HI  = 5'd3;
    localparam logic [4:0] CODE_SHIFT_UP = 5'd4;
    localparam logic [4:0] CODE_SHIFT_PU = 5'd5;
    localparam logic [4:0] CODE_ESCAPE   = 5'd6;
    localparam logic [4:0] TABLE_BASE    = 5'd6;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;

    // Punctuation alphabet, indexed by code minus the table base.
    localparam logic [7:0] PUNCT_TAB [26] = '{
        8'h20, 8'h0A, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h5F, 8'h23, 8'h27, 8'h22,
        8'h2F, 8'h5C, 8'h2D, 8'h3A, 8'h28, 8'h29
    };

    t_alpha     r_alpha;
    t_pend      r_pend;
    logic [4:0] r_held;

    t_alpha     n_alpha;
    t_pend      n_pend;
    logic [4:0] n_held;
    logic [1:0] n_count;
    t_group     n_group;
    logic       accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    // Walk the three codes of the word through the decoder state.
    always_comb begin
        logic [4:0] code;
        logic [4:0] idx;
        logic [7:0] ch;
        logic       emit;
        t_token     tok;
        n_alpha = i_in_item.start_of_string ? ALPHA_LOWER : r_alpha;
        n_pend  = i_in_item.start_of_string ? PEND_NONE   : r_pend;
        n_held  = i_in_item.start_of_string ? 5'd0        : r_held;
        n_count = 2'd0;
        n_group = '0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            code = i_in_item.text_word[14 - 5 * i -: 5];
            idx  = code - TABLE_BASE;
            emit = 1'b0;
            tok  = '0;
            ch   = '0;
            unique case (n_pend)
                PEND_ABBR: begin
                    emit   = 1'b1;
                    tok    = '{kind: KIND_ABBR,
                               value: {3'b000, n_held[1:0] - 2'd1, code}};
                    n_pend = PEND_NONE;
                end
                PEND_ESC_TOP: begin
                    n_held = code;
                    n_pend = PEND_ESC_BOT;
                end
                PEND_ESC_BOT: begin
                    emit   = 1'b1;
                    tok    = '{kind: KIND_ESC, value: {n_held, code}};
                    n_pend = PEND_NONE;
                end
                default: begin
                    if (code >= CODE_ABBR_LO && code <= CODE_ABBR_HI) begin
                        n_held = code;
                        n_pend = PEND_ABBR;
                    end else if (code == CODE_SHIFT_UP) begin
                        n_alpha = ALPHA_UPPER;
                    end else if (code == CODE_SHIFT_PU) begin
                        n_alpha = ALPHA_PUNCT;
                    end else if (code == CODE_SPACE) begin
                        emit    = 1'b1;
                        tok     = '{kind: KIND_CHAR, value: {2'b00, ASCII_SPACE}};
                        n_alpha = ALPHA_LOWER;
                    end else if (n_alpha == ALPHA_PUNCT && code == CODE_ESCAPE) begin
                        n_pend  = PEND_ESC_TOP;
                        n_alpha = ALPHA_LOWER;
                    end else begin
                        case (n_alpha)
                            ALPHA_UPPER: ch = ASCII_UPPER_A + {3'b000, idx};
                            ALPHA_PUNCT: ch = PUNCT_TAB[idx];
                            default:     ch = ASCII_LOWER_A + {3'b000, idx};
                        endcase
                        emit    = 1'b1;
                        tok     = '{kind: KIND_CHAR, value: {2'b00, ch}};
                        n_alpha = ALPHA_LOWER;
                    end
                end
            endcase
            if (emit) begin
                n_group.tok[n_count] = tok;
                n_count = n_count + 2'd1;
            end
        end
        n_group.count = n_count;
    end

    assign o_push  = accept && (n_count != 2'd0);
    assign o_group = n_group;

    // Decoder state advances once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_LOWER;
            r_pend  <= PEND_NONE;
            r_held  <= '0;
        end else if (accept) begin
            r_alpha <= n_alpha;
            r_pend  <= n_pend;
            r_held  <= n_held;
        end
    end

endmodule

// File: rtl/zctd_queue.sv
module zctd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  zctd_pkg::t_group i_group,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_head_valid,
    output zctd_pkg::t_group o_head
);
    import zctd_pkg::*;

    t_group     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

// File: rtl/zctd_back.sv
module zctd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  zctd_pkg::t_group   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output zctd_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import zctd_pkg::*;

    logic       r_out_valid;
    t_out_item  r_out_item;
    logic [1:0] r_idx;

    logic       load;
    logic       is_last;
    logic [1:0] n_idx;
    t_token     cur;

    // A token moves into the output register whenever it is free or draining.
    assign load    = i_head_valid && (!r_out_valid || !i_out_stall);
    assign is_last = (r_idx == i_head.count - 2'd1);
    assign o_pop   = load && is_last;
    assign n_idx   = is_last ? 2'd0 : r_idx + 2'd1;
    assign cur     = i_head.tok[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= n_idx;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= '{token_kind: cur.kind, token_value: cur.value,
                            last_of_run: is_last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/zchar_text_decoder.sv
// Decodes packed three-code text words into typed tokens (character, abbreviation
// number, escape value), one token per output transaction, with last_of_run marking
// the final token of each word. A word is accepted whenever the two-entry queue
// between the decoder and the output stage has room, and it reaches the output
// through the queue and the output register; words that yield no token leave no
// trace on the output. The single output register sends one token per cycle while
// the output is not stalled, and the queue keeps taking new words while earlier
// ones are still being sent, as long as it has room.
module zchar_text_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  zctd_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output zctd_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import zctd_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   head_valid;
    t_group push_group;
    t_group head_group;

    zctd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_full     (full),
        .o_push     (push),
        .o_group    (push_group)
    );

    zctd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_group      (push_group),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_group)
    );

    zctd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_group),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

endmodule

// File: rtl/zctd_checker.sv
`include "zchar_text_decoder_macros.svh"

module zctd_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input zctd_pkg::t_in_item  i_in_item,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input zctd_pkg::t_out_item o_out_item,
    input logic                i_out_stall
);
    import zctd_pkg::*;

    logic kind_legal;
    logic out_char;
    logic out_abbr;
    logic char_in_range;
    logic abbr_in_range;

    // Decoded views of the output transaction.
    assign kind_legal    = (o_out_item.token_kind == KIND_CHAR)
                        || (o_out_item.token_kind == KIND_ABBR)
                        || (o_out_item.token_kind == KIND_ESC);
    assign out_char      = o_out_valid && (o_out_item.token_kind == KIND_CHAR);
    assign out_abbr      = o_out_valid && (o_out_item.token_kind == KIND_ABBR);
    assign char_in_range = (o_out_item.token_value[9:8] == 2'b00);
    assign abbr_in_range = (o_out_item.token_value[9:7] == 3'b000)
                        && (o_out_item.token_value[6:5] != 2'b11);

    // A stalled output transaction holds its payload.
    `ZCTD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // Only the three defined token kinds appear.
    `ZCTD_ASSERT_NOW(a_kind_legal, o_out_valid, kind_legal)

    // Characters are single bytes.
    `ZCTD_ASSERT_NOW(a_char_byte, out_char, char_in_range)

    // Abbreviation numbers stay below 96.
    `ZCTD_ASSERT_NOW(a_abbr_range, out_abbr, abbr_in_range)

endmodule

bind zchar_text_decoder zctd_props u_zctd_props (.*);

// File: test/zctd_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the text decoder, predicts the tokens of every
// accepted word and compares them with the tokens that leave the block.
module zctd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  zctd_pkg::t_in_item  i_in_item,
    input  logic                i_in_stall,
    input  logic                i_out_valid,
    input  zctd_pkg::t_out_item i_out_item,
    input  logic                i_out_stall,
    output int                  o_fail_count,
    output int                  o_outstanding,
    output int                  o_token_count
);
    import zctd_pkg::*;

    // Active character set.
    localparam logic [1:0] ALPH_LOWER = 2'd0;
    localparam logic [1:0] ALPH_UPPER = 2'd1;
    localparam logic [1:0] ALPH_PUNCT = 2'd2;

    // Multi-code sequence in progress.
    localparam logic [1:0] SEQ_NONE    = 2'd0;
    localparam logic [1:0] SEQ_ABBR    = 2'd1;
    localparam logic [1:0] SEQ_ESC_TOP = 2'd2;
    localparam logic [1:0] SEQ_ESC_BOT = 2'd3;

    // Special code values.
    localparam logic [4:0] CODE_SPACE       = 5'd0;
    localparam logic [4:0] CODE_ABBR_FIRST  = 5'd1;
    localparam logic [4:0] CODE_ABBR_LAST   = 5'd3;
    localparam logic [4:0] CODE_SHIFT_UPPER = 5'd4;
    localparam logic [4:0] CODE_SHIFT_PUNCT = 5'd5;
    localparam logic [4:0] CODE_ESCAPE      = 5'd6;
    localparam logic [4:0] CODE_TABLE_BASE  = 5'd6;

    localparam logic [9:0] ASCII_SPACE = 10'd32;
    localparam int         MAX_REPORTS = 10;

    // Punctuation set for codes 6 through 31, first character in the top byte.
    localparam logic [26*8-1:0] PUNCT_GLYPHS = " \n0123456789.,!?_#'\"/\\-:()";

    logic [1:0] alph;
    logic [1:0] pend;
    logic [4:0] held;
    t_out_item  token_q [$];
    int         fail_cnt;
    int         token_cnt;

    function automatic logic [7:0] glyph(input logic [1:0] set, input logic [4:0] code);
        logic [7:0] off;
        off = {3'b000, 5'(code - CODE_TABLE_BASE)};
        case (set)
            ALPH_UPPER: return 8'h41 + off;
            ALPH_PUNCT: return PUNCT_GLYPHS[8*(25 - off) +: 8];
            default:    return 8'h61 + off;
        endcase
    endfunction

    function automatic t_out_item make_token(input logic [1:0] kind, input logic [9:0] value);
        t_out_item tok;
        tok.token_kind  = kind;
        tok.token_value = value;
        tok.last_of_run = 1'b0;
        return tok;
    endfunction

    // Decode one word into its tokens and queue them as expectations.
    task automatic decode_word(input t_in_item item);
        t_out_item  toks [MAX_TOKENS];
        int         n;
        int         i;
        logic [4:0] code;
        n = 0;
        if (item.start_of_string) begin
            alph = ALPH_LOWER;
            pend = SEQ_NONE;
            held = '0;
        end
        for (i = 0; i < 3; i = i + 1) begin
            code = item.text_word[14 - 5*i -: 5];
            case (pend)
                SEQ_ABBR: begin
                    // Index code is taken raw; the pending shift survives.
                    toks[n] = make_token(KIND_ABBR, {held - 5'd1, code});
                    n = n + 1;
                    pend = SEQ_NONE;
                end
                SEQ_ESC_TOP: begin
                    held = code;
                    pend = SEQ_ESC_BOT;
                end
                SEQ_ESC_BOT: begin
                    toks[n] = make_token(KIND_ESC, {held, code});
                    n = n + 1;
                    pend = SEQ_NONE;
                end
                default: begin
                    if (code >= CODE_ABBR_FIRST && code <= CODE_ABBR_LAST) begin
                        held = code;
                        pend = SEQ_ABBR;
                    end else if (code == CODE_SHIFT_UPPER) begin
                        alph = ALPH_UPPER;
                    end else if (code == CODE_SHIFT_PUNCT) begin
                        alph = ALPH_PUNCT;
                    end else if (code == CODE_SPACE) begin
                        toks[n] = make_token(KIND_CHAR, ASCII_SPACE);
                        n = n + 1;
                        alph = ALPH_LOWER;
                    end else if (alph == ALPH_PUNCT && code == CODE_ESCAPE) begin
                        pend = SEQ_ESC_TOP;
                        alph = ALPH_LOWER;
                    end else begin
                        toks[n] = make_token(KIND_CHAR, {2'b00, glyph(alph, code)});
                        n = n + 1;
                        alph = ALPH_LOWER;
                    end
                end
            endcase
        end
        if (n > 0) begin
            toks[n-1].last_of_run = 1'b1;
        end
        for (i = 0; i < n; i = i + 1) begin
            token_q.push_back(toks[i]);
        end
    endtask

    task automatic report(input string what, input t_out_item want, input t_out_item got);
        fail_cnt = fail_cnt + 1;
        if (fail_cnt <= MAX_REPORTS) begin
            $display("%t: %s: expected kind %0d value 0x%03h last %b,",
                     $realtime, what, want.token_kind, want.token_value, want.last_of_run);
            $display("    got kind %0d value 0x%03h last %b",
                     got.token_kind, got.token_value, got.last_of_run);
        end
    endtask

    initial begin
        alph      = ALPH_LOWER;
        pend      = SEQ_NONE;
        held      = '0;
        fail_cnt  = 0;
        token_cnt = 0;
    end

    // Predict on each accepted word, then compare each accepted token.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            alph = ALPH_LOWER;
            pend = SEQ_NONE;
            held = '0;
            token_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                decode_word(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                token_cnt = token_cnt + 1;
                if (token_q.size() == 0) begin
                    report("token with none expected", '0, i_out_item);
                end else begin
                    want = token_q.pop_front();
                    if (i_out_item.token_kind !== want.token_kind
                            || i_out_item.token_value !== want.token_value
                            || i_out_item.last_of_run !== want.last_of_run) begin
                        report("token mismatch", want, i_out_item);
                    end
                end
            end
        end
        o_fail_count  <= fail_cnt;
        o_outstanding <= token_q.size();
        o_token_count <= token_cnt;
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

// Drives words into the text decoder under several idling patterns and
// reports the verdict from the checker's failure and outstanding counts.
module tb_top;
    import zctd_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 60;
    localparam int RANDOM_WORDS  = 62;
    localparam int DRAIN_CYCLES  = 20;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    int fail_count;
    int outstanding;
    int token_count;

    // Idling controls for the sender and the receiver, and run counters.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int words_sent    = 0;
    int restarts      = 0;

    t_in_item directed_q [$];

    zchar_text_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    zctd_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_item     (in_item),
        .i_in_stall    (in_stall),
        .i_out_valid   (out_valid),
        .i_out_item    (out_item),
        .i_out_stall   (out_stall),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_token_count (token_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_in_item pack_word(input logic sos, input logic hi,
                                           input logic [4:0] a, input logic [4:0] b,
                                           input logic [4:0] c);
        t_in_item item;
        item.text_word       = {hi, a, b, c};
        item.start_of_string = sos;
        return item;
    endfunction

    // Weighted toward shifts and sequence starters so that sequences form often.
    function automatic logic [4:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 8)       return 5'd0;
        else if (r < 20) return 5'($urandom_range(3, 1));
        else if (r < 30) return 5'd4;
        else if (r < 42) return 5'd5;
        else if (r < 52) return 5'd6;
        else             return 5'($urandom_range(31, 6));
    endfunction

    // Offer one word from a falling edge and return at the falling edge after acceptance.
    task automatic push_word(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent = words_sent + 1;
        if (item.start_of_string) begin
            restarts = restarts + 1;
        end
        @(negedge clk);
    endtask

    // Receiver stall, with a long hold-off whenever one is requested.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int        p;
        int        i;
        t_in_item  item;
        int        phase_send [4];
        int        phase_stall [4];

        phase_send  = '{0, 57, 0, 38};
        phase_stall = '{0, 0, 57, 38};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;

        // Plain characters, shifts, abbreviations, escapes and restarts.
        directed_q.push_back(pack_word(1'b1, 1'b0, 5'd0, 5'd6, 5'd31));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd4, 5'd6, 5'd4));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd31, 5'd5, 5'd7));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd5, 5'd8, 5'd5));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd31, 5'd4, 5'd5));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd9, 5'd4, 5'd5));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd4, 5'd5, 5'd4));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd1, 5'd0, 5'd2));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd31, 5'd3, 5'd31));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd6, 5'd4, 5'd1));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd5, 5'd10, 5'd0));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd5, 5'd6, 5'd31));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd31, 5'd5, 5'd6));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd0, 5'd4, 5'd6));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd5, 5'd6, 5'd3));
        directed_q.push_back(pack_word(1'b1, 1'b0, 5'd6, 5'd6, 5'd6));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd2, 5'd2, 5'd2));
        directed_q.push_back(pack_word(1'b1, 1'b0, 5'd7, 5'd0, 5'd7));
        directed_q.push_back(pack_word(1'b0, 1'b1, 5'd5, 5'd4, 5'd31));
        directed_q.push_back(pack_word(1'b0, 1'b1, 5'd31, 5'd31, 5'd31));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd0, 5'd0, 5'd0));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd3, 5'd6, 5'd5));
        directed_q.push_back(pack_word(1'b0, 1'b0, 5'd6, 5'd0, 5'd0));
        directed_q.push_back(pack_word(1'b1, 1'b0, 5'd5, 5'd7, 5'd1));
        directed_q.push_back(pack_word(1'b0, 1'b1, 5'd31, 5'd5, 5'd20));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_q[i]) begin
            push_word(directed_q[i]);
        end

        // Random words under each idling pattern; the first phase also holds
        // off the receiver long enough for the block to back up.
        for (p = 0; p < 4; p = p + 1) begin
            send_idle_pct = phase_send[p];
            stall_pct     = phase_stall[p];
            if (p == 0) begin
                hold_asks = hold_asks + 1;
            end
            for (i = 0; i < RANDOM_WORDS; i = i + 1) begin
                if ($urandom_range(4) == 0) begin
                    item.text_word = 16'($urandom);
                end else begin
                    item.text_word = {1'($urandom), pick_code(), pick_code(), pick_code()};
                end
                item.start_of_string = ($urandom_range(15) == 0);
                push_word(item);
            end
        end

        in_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words (%0d string restarts) through directed and random phases,",
                 words_sent, restarts);
        $display("with sender gaps, receiver stalls and one long hold-off; %0d tokens checked.",
                 token_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/zctd_pkg.sv
rtl/zctd_front.sv
rtl/zctd_queue.sv
rtl/zctd_back.sv
rtl/zchar_text_decoder.sv
rtl/zctd_checker.sv
test/zctd_checker.sv
test/tb_top.sv
